// ===== rtl/core/swsr_pkg.sv =====
// ----------------------------------------------------------------------------
// swsr_pkg
// Shared types and constants of the single-wire sensor reader core.
// ----------------------------------------------------------------------------
package swsr_pkg;

    localparam int FRAME_BITS  = 40;
    localparam int CNT_W       = 16;
    localparam int BIT_IDX_W   = 7;
    localparam int HUM_W       = 16;
    localparam int TEMP_W      = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DELAY_W     = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_START_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_DELAY = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RESPONSE_GAP = 2'd3;

    // register reset values
    localparam logic [CNT_W-1:0]   START_LOW_RST    = 16'd1000;
    localparam logic [DELAY_W-1:0] START_HIGH_RST   = 8'd30;
    localparam logic [DELAY_W-1:0] SAMPLE_DELAY_RST = 8'd40;
    localparam logic [DELAY_W-1:0] RESPONSE_GAP_RST = 8'd80;

    // line drive codes
    localparam logic [1:0] DRIVE_RELEASE = 2'd0;
    localparam logic [1:0] DRIVE_LOW     = 2'd1;
    localparam logic [1:0] DRIVE_HIGH    = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START_LOW  = 4'd1,
        PH_START_HIGH = 4'd2,
        PH_RESP_LOW   = 4'd3,
        PH_RESP_GAP   = 4'd4,
        PH_RESP_END   = 4'd5,
        PH_WAIT_RISE  = 4'd6,
        PH_BIT_DELAY  = 4'd7,
        PH_WAIT_FALL  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [CNT_W-1:0]   start_low_ticks;
        logic [DELAY_W-1:0] start_high_ticks;
        logic [DELAY_W-1:0] sample_delay_ticks;
        logic [DELAY_W-1:0] response_gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic cmd;
        logic line_level;
    } item_t;

    typedef struct packed {
        logic [1:0]        line_drive;
        logic              busy_res;
        logic              result_valid;
        logic              response_ok;
        logic [HUM_W-1:0]  humidity_tenths;
        logic [TEMP_W-1:0] temperature_tenths;
        logic              temperature_negative;
    } result_t;

endpackage

// ===== rtl/core/single_wire_sensor_reader_core.sv =====
// ----------------------------------------------------------------------------
// single_wire_sensor_reader_core
// Tick-driven readout sequencer for a single-wire humidity/temperature sensor.
//
// Usage: every item on the item channel is one microsecond tick carrying the
// sampled data-line level (cmd = 0), or a start request (cmd = 1) which
// begins a measurement when idle. Every item yields exactly one transaction
// on the res channel with the line drive, busy flag and, on the finishing
// tick, the measurement result. The cfg channel writes the four timing
// registers and is always ready; write only while the core is idle.
// An accepted item waits in the input register, then moves on into the result
// register, where the receiver takes it.
// Throughput: one item per cycle while the receiver does not stall; the sequencer
// state updates once per item, between the input and result registers.
// Reset puts the sequencer in idle and loads the default timing.
// When the receiver stalls, the result register holds its transaction, the
// input register still takes one more item, then item_ready drops.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader_core
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              cmd,
    input  logic                              line_level,

    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [1:0]                        line_drive,
    output logic                              busy_res,
    output logic                              result_valid,
    output logic                              response_ok,
    output logic [swsr_pkg::HUM_W-1:0]        humidity_tenths,
    output logic [swsr_pkg::TEMP_W-1:0]       temperature_tenths,
    output logic                              temperature_negative,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    swsr_pkg::cfg_t    cfg;
    swsr_pkg::item_t   item_in;
    swsr_pkg::item_t   stage_item;
    swsr_pkg::result_t seq_result;
    swsr_pkg::result_t res;
    logic              stage_valid;
    logic              advance;

    assign cfg_ready          = 1'b1;
    assign item_in.cmd        = cmd;
    assign item_in.line_level = line_level;

    swsr_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    swsr_in_reg u_in_reg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_in     (item_in),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    swsr_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (stage_item),
        .cfg     (cfg),
        .result  (seq_result)
    );

    swsr_out_reg u_out_reg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .result_in   (seq_result),
        .advance     (advance),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .result_out  (res)
    );

    assign line_drive           = res.line_drive;
    assign busy_res             = res.busy_res;
    assign result_valid         = res.result_valid;
    assign response_ok          = res.response_ok;
    assign humidity_tenths      = res.humidity_tenths;
    assign temperature_tenths   = res.temperature_tenths;
    assign temperature_negative = res.temperature_negative;

    // a good response only comes with a finished measurement
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && response_ok |-> result_valid)
        else $error("response_ok without result_valid");

    // data fields stay zero unless a good result is reported
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !response_ok |->
            humidity_tenths == '0 && temperature_tenths == '0 && !temperature_negative)
        else $error("data fields set without a good result");

    // a finished measurement returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_valid |-> !busy_res && line_drive == swsr_pkg::DRIVE_RELEASE)
        else $error("result reported while still busy");

    // the line is only driven during a measurement
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && line_drive != swsr_pkg::DRIVE_RELEASE |-> busy_res)
        else $error("line driven while idle");

endmodule

// ===== rtl/core/swsr_cfg.sv =====
// ----------------------------------------------------------------------------
// swsr_cfg
// Configuration register file: start timing, sample delay and response gap.
// ----------------------------------------------------------------------------
module swsr_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [swsr_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]   wr_data,
    output swsr_pkg::cfg_t                    cfg
);

    swsr_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks    <= swsr_pkg::START_LOW_RST;
            cfg_reg.start_high_ticks   <= swsr_pkg::START_HIGH_RST;
            cfg_reg.sample_delay_ticks <= swsr_pkg::SAMPLE_DELAY_RST;
            cfg_reg.response_gap_ticks <= swsr_pkg::RESPONSE_GAP_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                swsr_pkg::REG_START_LOW:
                    cfg_reg.start_low_ticks <= wr_data;
                swsr_pkg::REG_START_HIGH:
                    cfg_reg.start_high_ticks <= wr_data[swsr_pkg::DELAY_W-1:0];
                swsr_pkg::REG_SAMPLE_DELAY:
                    cfg_reg.sample_delay_ticks <= wr_data[swsr_pkg::DELAY_W-1:0];
                swsr_pkg::REG_RESPONSE_GAP:
                    cfg_reg.response_gap_ticks <= wr_data[swsr_pkg::DELAY_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/swsr_in_reg.sv =====
// ----------------------------------------------------------------------------
// swsr_in_reg
// Input register stage holding one accepted tick or start transaction.
// ----------------------------------------------------------------------------
module swsr_in_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  swsr_pkg::item_t item_in,
    input  logic            advance,
    output logic            stage_valid,
    output swsr_pkg::item_t stage_item
);

    logic            valid_reg;
    logic            valid_next;
    swsr_pkg::item_t item_reg;

    // the stage frees up in the same cycle its content moves on
    assign item_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_ready)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item_in;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// ===== rtl/core/swsr_seq.sv =====
// ----------------------------------------------------------------------------
// swsr_seq
// Readout sequencer: start pulse, response check and frame bit capture,
// one tick per advance.
// ----------------------------------------------------------------------------
module swsr_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  swsr_pkg::item_t   item,
    input  swsr_pkg::cfg_t    cfg,
    output swsr_pkg::result_t result
);

    swsr_pkg::phase_t                  phase_reg;
    swsr_pkg::phase_t                  phase_next;
    logic [swsr_pkg::CNT_W-1:0]        tick_reg;
    logic [swsr_pkg::CNT_W-1:0]        tick_next;
    logic [swsr_pkg::BIT_IDX_W-1:0]    bit_reg;
    logic [swsr_pkg::BIT_IDX_W-1:0]    bit_next;
    logic [swsr_pkg::FRAME_BITS-1:0]   frame_reg;
    logic [swsr_pkg::FRAME_BITS-1:0]   frame_next;
    logic                              answer_reg;
    logic                              answer_next;

    logic [swsr_pkg::CNT_W-1:0]        tick_inc;
    logic [swsr_pkg::CNT_W-1:0]        limit;
    logic                              count_hit;
    logic                              done;
    logic                              ok;

    assign tick_inc = tick_reg + swsr_pkg::CNT_W'(1);

    // wait length of the current phase
    always_comb
    begin
        case (phase_reg)
            swsr_pkg::PH_START_LOW:  limit = cfg.start_low_ticks;
            swsr_pkg::PH_START_HIGH: limit = swsr_pkg::CNT_W'(cfg.start_high_ticks);
            swsr_pkg::PH_RESP_LOW,
            swsr_pkg::PH_BIT_DELAY:  limit = swsr_pkg::CNT_W'(cfg.sample_delay_ticks);
            swsr_pkg::PH_RESP_GAP:   limit = swsr_pkg::CNT_W'(cfg.response_gap_ticks);
            default:                 limit = '0;
        endcase
    end

    // a zero limit ends the wait after one tick
    assign count_hit = (tick_inc >= limit);

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        frame_next  = frame_reg;
        answer_next = answer_reg;
        done        = 1'b0;
        ok          = 1'b0;

        unique case (phase_reg)
            swsr_pkg::PH_START_LOW:
            begin
                tick_next = count_hit ? '0 : tick_inc;
                if (count_hit)
                begin
                    phase_next = swsr_pkg::PH_START_HIGH;
                end
            end
            swsr_pkg::PH_START_HIGH:
            begin
                tick_next = count_hit ? '0 : tick_inc;
                if (count_hit)
                begin
                    phase_next = swsr_pkg::PH_RESP_LOW;
                end
            end
            swsr_pkg::PH_RESP_LOW:
            begin
                tick_next = count_hit ? '0 : tick_inc;
                if (count_hit)
                begin
                    if (!item.line_level)
                    begin
                        phase_next = swsr_pkg::PH_RESP_GAP;
                    end
                    else
                    begin
                        answer_next = 1'b0;
                        phase_next  = swsr_pkg::PH_RESP_END;
                    end
                end
            end
            swsr_pkg::PH_RESP_GAP:
            begin
                tick_next = count_hit ? '0 : tick_inc;
                if (count_hit)
                begin
                    answer_next = item.line_level;
                    phase_next  = swsr_pkg::PH_RESP_END;
                end
            end
            swsr_pkg::PH_RESP_END:
            begin
                if (!item.line_level)
                begin
                    if (answer_reg)
                    begin
                        bit_next   = '0;
                        frame_next = '0;
                        phase_next = swsr_pkg::PH_WAIT_RISE;
                    end
                    else
                    begin
                        done       = 1'b1;
                        phase_next = swsr_pkg::PH_IDLE;
                    end
                end
            end
            swsr_pkg::PH_WAIT_RISE:
            begin
                if (item.line_level)
                begin
                    tick_next  = '0;
                    phase_next = swsr_pkg::PH_BIT_DELAY;
                end
            end
            swsr_pkg::PH_BIT_DELAY:
            begin
                tick_next = count_hit ? '0 : tick_inc;
                if (count_hit)
                begin
                    frame_next = {frame_reg[swsr_pkg::FRAME_BITS-2:0], item.line_level};
                    bit_next   = bit_reg + swsr_pkg::BIT_IDX_W'(1);
                    phase_next = swsr_pkg::PH_WAIT_FALL;
                end
            end
            swsr_pkg::PH_WAIT_FALL:
            begin
                if (!item.line_level)
                begin
                    if (bit_reg >= swsr_pkg::BIT_IDX_W'(swsr_pkg::FRAME_BITS))
                    begin
                        done       = 1'b1;
                        ok         = 1'b1;
                        phase_next = swsr_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = swsr_pkg::PH_WAIT_RISE;
                    end
                end
            end
            default:
            begin
                // idle, and any unused code
                phase_next = swsr_pkg::PH_IDLE;
                if (item.cmd)
                begin
                    phase_next  = swsr_pkg::PH_START_LOW;
                    tick_next   = '0;
                    answer_next = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= swsr_pkg::PH_IDLE;
            tick_reg   <= '0;
            bit_reg    <= '0;
            frame_reg  <= '0;
            answer_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            frame_reg  <= frame_next;
            answer_reg <= answer_next;
        end
    end

    // result fields follow the phase after this tick
    always_comb
    begin
        case (phase_next)
            swsr_pkg::PH_START_LOW:  result.line_drive = swsr_pkg::DRIVE_LOW;
            swsr_pkg::PH_START_HIGH: result.line_drive = swsr_pkg::DRIVE_HIGH;
            default:                 result.line_drive = swsr_pkg::DRIVE_RELEASE;
        endcase
        result.busy_res     = (phase_next != swsr_pkg::PH_IDLE);
        result.result_valid = done;
        result.response_ok  = ok;
        if (ok)
        begin
            result.humidity_tenths =
                frame_next[swsr_pkg::FRAME_BITS-1 -: swsr_pkg::HUM_W];
            result.temperature_negative =
                frame_next[swsr_pkg::FRAME_BITS-1-swsr_pkg::HUM_W];
            result.temperature_tenths =
                frame_next[swsr_pkg::FRAME_BITS-2-swsr_pkg::HUM_W -: swsr_pkg::TEMP_W];
        end
        else
        begin
            result.humidity_tenths      = '0;
            result.temperature_negative = 1'b0;
            result.temperature_tenths   = '0;
        end
    end

endmodule

// ===== rtl/core/swsr_out_reg.sv =====
// ----------------------------------------------------------------------------
// swsr_out_reg
// Result register holding one transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module swsr_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              stage_valid,
    input  swsr_pkg::result_t result_in,
    output logic              advance,
    output logic              res_valid,
    input  logic              res_ready,
    output swsr_pkg::result_t result_out
);

    logic              valid_reg;
    logic              valid_next;
    swsr_pkg::result_t result_reg;

    // move on when the register is empty or being emptied this cycle
    assign advance = stage_valid && (!valid_reg || res_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_in;
        end
    end

    assign res_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== dv/single_wire_sensor_reader_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// single_wire_sensor_reader_core_test
// Self-checking bench for the sensor readout sequencer. A behavioral sensor
// answers each start with a response and a data frame, or with a broken
// response, timed by the current timing registers. Every tick runs through a
// local sequencer copy; each res transaction is compared with it field by field.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader_core_test;

    import swsr_pkg::*;

    typedef enum int {
        ANSWER_OK,
        ANSWER_NO_LOW,
        ANSWER_NO_HIGH
    } answer_t;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_TICKS  = 300;

    logic                    clk;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_ready;
    logic                    cmd;
    logic                    line_level;
    logic                    res_valid;
    logic                    res_ready;
    logic [1:0]              line_drive;
    logic                    busy_res;
    logic                    result_valid;
    logic                    response_ok;
    logic [HUM_W-1:0]        humidity_tenths;
    logic [TEMP_W-1:0]       temperature_tenths;
    logic                    temperature_negative;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // local sequencer copy
    cfg_t                    timing;
    phase_t                  seq_phase;
    logic [CNT_W-1:0]        seq_ticks;
    logic [BIT_IDX_W-1:0]    seq_bits;
    logic [FRAME_BITS-1:0]   seq_frame;
    logic                    seq_answered;

    result_t                 expected_readouts[$];
    int                      errors = 0;
    int                      cycle_count = 0;
    int                      driven_ticks = 0;
    bit                      gaps_on = 1'b1;
    bit                      stalls_on = 1'b1;

    single_wire_sensor_reader_core DUT
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .item_valid           (item_valid),
        .item_ready           (item_ready),
        .cmd                  (cmd),
        .line_level           (line_level),
        .res_valid            (res_valid),
        .res_ready            (res_ready),
        .line_drive           (line_drive),
        .busy_res             (busy_res),
        .result_valid         (result_valid),
        .response_ok          (response_ok),
        .humidity_tenths      (humidity_tenths),
        .temperature_tenths   (temperature_tenths),
        .temperature_negative (temperature_negative),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver side: random stall bursts
    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 7) == 0)
            begin
                res_ready = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
            begin
                res_ready = 1'b1;
            end
        end
    end

    // true when the running wait of the given length ends on this tick
    function automatic logic wait_ends(input logic [CNT_W-1:0] limit);
        logic [CNT_W-1:0] nxt;
        nxt = seq_ticks + CNT_W'(1);
        return nxt >= limit;
    endfunction

    task automatic count_tick(input logic [CNT_W-1:0] limit, output logic done);
        done = wait_ends(limit);
        seq_ticks = done ? '0 : seq_ticks + CNT_W'(1);
    endtask

    task automatic advance_sequencer(input logic c, input logic lvl, output result_t r);
        logic done;
        logic finished;
        logic answered_ok;
        finished = 1'b0;
        answered_ok = 1'b0;
        case (seq_phase)
            PH_START_LOW:
            begin
                count_tick(timing.start_low_ticks, done);
                if (done) seq_phase = PH_START_HIGH;
            end
            PH_START_HIGH:
            begin
                count_tick({8'd0, timing.start_high_ticks}, done);
                if (done) seq_phase = PH_RESP_LOW;
            end
            PH_RESP_LOW:
            begin
                count_tick({8'd0, timing.sample_delay_ticks}, done);
                if (done)
                begin
                    if (!lvl)
                        seq_phase = PH_RESP_GAP;
                    else
                    begin
                        seq_answered = 1'b0;
                        seq_phase = PH_RESP_END;
                    end
                end
            end
            PH_RESP_GAP:
            begin
                count_tick({8'd0, timing.response_gap_ticks}, done);
                if (done)
                begin
                    seq_answered = lvl;
                    seq_phase = PH_RESP_END;
                end
            end
            PH_RESP_END:
            begin
                if (!lvl)
                begin
                    if (seq_answered)
                    begin
                        seq_bits = '0;
                        seq_frame = '0;
                        seq_phase = PH_WAIT_RISE;
                    end
                    else
                    begin
                        finished = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                end
            end
            PH_WAIT_RISE:
            begin
                if (lvl)
                begin
                    seq_ticks = '0;
                    seq_phase = PH_BIT_DELAY;
                end
            end
            PH_BIT_DELAY:
            begin
                count_tick({8'd0, timing.sample_delay_ticks}, done);
                if (done)
                begin
                    seq_frame = {seq_frame[FRAME_BITS-2:0], lvl};
                    seq_bits = seq_bits + BIT_IDX_W'(1);
                    seq_phase = PH_WAIT_FALL;
                end
            end
            PH_WAIT_FALL:
            begin
                if (!lvl)
                begin
                    if (seq_bits >= BIT_IDX_W'(FRAME_BITS))
                    begin
                        finished = 1'b1;
                        answered_ok = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                    else
                    begin
                        seq_phase = PH_WAIT_RISE;
                    end
                end
            end
            default:
            begin
                seq_phase = PH_IDLE;
                if (c)
                begin
                    seq_phase = PH_START_LOW;
                    seq_ticks = '0;
                    seq_answered = 1'b0;
                end
            end
        endcase

        r = '0;
        if (seq_phase == PH_START_LOW)
            r.line_drive = DRIVE_LOW;
        else if (seq_phase == PH_START_HIGH)
            r.line_drive = DRIVE_HIGH;
        else
            r.line_drive = DRIVE_RELEASE;
        r.busy_res = (seq_phase != PH_IDLE);
        r.result_valid = finished;
        r.response_ok = answered_ok;
        if (answered_ok)
        begin
            r.humidity_tenths = seq_frame[FRAME_BITS-1 -: HUM_W];
            r.temperature_negative = seq_frame[FRAME_BITS-17];
            r.temperature_tenths = seq_frame[FRAME_BITS-18 -: TEMP_W];
        end
    endtask

    // behavioral sensor: picks the line level for the next tick
    function automatic logic sensor_level(input logic [FRAME_BITS-1:0] word,
                                          input answer_t kind);
        logic lvl;
        lvl = 1'($urandom_range(0, 1));
        case (seq_phase)
            PH_RESP_LOW:
                if (wait_ends({8'd0, timing.sample_delay_ticks}))
                    lvl = (kind == ANSWER_NO_LOW);
            PH_RESP_GAP:
                if (wait_ends({8'd0, timing.response_gap_ticks}))
                    lvl = (kind != ANSWER_NO_HIGH);
            PH_RESP_END:
                lvl = ($urandom_range(0, 3) == 0);
            PH_WAIT_RISE:
                lvl = ($urandom_range(0, 3) != 0);
            PH_BIT_DELAY:
                if (wait_ends({8'd0, timing.sample_delay_ticks}))
                    lvl = word[FRAME_BITS - 1 - int'(seq_bits)];
            PH_WAIT_FALL:
                lvl = ($urandom_range(0, 3) == 0);
            default:
                ;
        endcase
        return lvl;
    endfunction

    function automatic logic [FRAME_BITS-1:0] random_frame();
        return FRAME_BITS'({$urandom, $urandom});
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic c, input logic lvl);
        result_t want;
        if (gaps_on && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 7)) @(negedge clk);
        if (c || seq_phase != PH_IDLE)
            driven_ticks++;
        advance_sequencer(c, lvl, want);
        expected_readouts.push_back(want);
        item_valid = 1'b1;
        cmd = c;
        line_level = lvl;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (expected_readouts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_START_LOW:    timing.start_low_ticks = data;
            REG_START_HIGH:   timing.start_high_ticks = data[DELAY_W-1:0];
            REG_SAMPLE_DELAY: timing.sample_delay_ticks = data[DELAY_W-1:0];
            REG_RESPONSE_GAP: timing.response_gap_ticks = data[DELAY_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // upper byte of the 8-bit registers is junk and must be dropped
    task automatic set_timing(input logic [CNT_W-1:0] low_ticks, input logic [7:0] high_ticks,
                              input logic [7:0] delay_ticks, input logic [7:0] gap_ticks);
        write_reg(REG_START_LOW, low_ticks);
        write_reg(REG_START_HIGH, {8'($urandom), high_ticks});
        write_reg(REG_SAMPLE_DELAY, {8'($urandom), delay_ticks});
        write_reg(REG_RESPONSE_GAP, {8'($urandom), gap_ticks});
    endtask

    task automatic shuffle_timing();
        set_timing(16'($urandom_range(0, 24)), 8'($urandom_range(0, 6)),
                   ($urandom_range(0, 7) == 0) ? 8'($urandom_range(7, 30))
                                              : 8'($urandom_range(0, 4)),
                   8'($urandom_range(0, 8)));
    endtask

    task automatic run_to_idle(input logic [FRAME_BITS-1:0] word, input answer_t kind,
                               input int busy_cmd_odds, input int glitch_odds);
        logic c;
        logic lvl;
        while (seq_phase != PH_IDLE)
        begin
            c = (busy_cmd_odds > 0) && ($urandom_range(0, busy_cmd_odds - 1) == 0);
            lvl = sensor_level(word, kind);
            if (glitch_odds > 0 && $urandom_range(0, glitch_odds - 1) == 0)
                lvl = 1'($urandom_range(0, 1));
            send_item(c, lvl);
        end
    endtask

    task automatic measure(input logic [FRAME_BITS-1:0] word, input answer_t kind,
                           input int busy_cmd_odds, input int glitch_odds);
        send_item(1'b1, 1'($urandom_range(0, 1)));
        run_to_idle(word, kind, busy_cmd_odds, glitch_odds);
    endtask

    task automatic test_idle_ticks();
        for (int i = 0; i < 6; i++)
            send_item(1'b0, 1'(i));
    endtask

    // start pulse runs on reset timing for a while, then gets cut short;
    // the rest of the sequence uses the reset timing as it is
    task automatic test_default_timing();
        send_item(1'b1, 1'($urandom_range(0, 1)));
        repeat (60)
            send_item(1'b0, 1'($urandom_range(0, 1)));
        write_reg(REG_START_LOW, 16'd2);
        run_to_idle(random_frame(), ANSWER_NO_HIGH, 0, 0);
    endtask

    task automatic test_frame_extremes();
        set_timing(16'd1, 8'd1, 8'd1, 8'd1);
        measure(FRAME_BITS'(1) << (FRAME_BITS - 17), ANSWER_OK, 0, 0);
        measure({16'hFFFF, 1'b0, 15'h0000, 8'hA5}, ANSWER_OK, 0, 0);
        measure({16'h0000, 1'b1, 15'h7FFF, 8'h5A}, ANSWER_OK, 0, 0);
    endtask

    task automatic test_no_response();
        measure(random_frame(), ANSWER_NO_LOW, 0, 0);
        measure(random_frame(), ANSWER_NO_HIGH, 0, 0);
    endtask

    task automatic test_start_while_busy();
        measure(random_frame(), ANSWER_OK, 2, 0);
    endtask

    task automatic test_zero_delays();
        set_timing(16'd0, 8'd0, 8'd0, 8'd0);
        measure(random_frame(), ANSWER_OK, 0, 0);
        measure(random_frame(), ANSWER_NO_HIGH, 0, 0);
    endtask

    task automatic test_random_traffic();
        int pick;
        driven_ticks = 0;
        while (driven_ticks < RANDOM_TICKS)
        begin
            if ($urandom_range(0, 2) == 0)
                shuffle_timing();
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 13)
                measure(random_frame(), ANSWER_OK, 16, 0);
            else if (pick < 15)
                measure(random_frame(), answer_t'($urandom_range(1, 2)), 16, 0);
            else if (pick < 17)
                measure(random_frame(), ANSWER_OK, 8, 6);
            else if (pick < 18)
                drain_results();
            else
            begin
                // noise, then finish whatever it started
                repeat ($urandom_range(1, 12))
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                run_to_idle(random_frame(), ANSWER_OK, 0, 0);
            end
        end
    endtask

    // longest start high and sample delay, back to back with no stalls
    task automatic test_slow_extremes();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        set_timing(16'd4, 8'hFF, 8'hFF, 8'hFF);
        measure(random_frame(), ANSWER_NO_LOW, 4, 0);
    endtask

    function automatic int field_diff(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin : check_readout
        result_t got;
        result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            got = {line_drive, busy_res, result_valid, response_ok, humidity_tenths,
                   temperature_tenths, temperature_negative};
            if (expected_readouts.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none actual %h",
                         $time, got);
                errors++;
            end
            else
            begin
                want = expected_readouts.pop_front();
                errors += field_diff("line_drive", 16'(want.line_drive),
                                     16'(got.line_drive));
                errors += field_diff("busy_res", 16'(want.busy_res), 16'(got.busy_res));
                errors += field_diff("result_valid", 16'(want.result_valid),
                                     16'(got.result_valid));
                errors += field_diff("response_ok", 16'(want.response_ok),
                                     16'(got.response_ok));
                errors += field_diff("humidity_tenths", want.humidity_tenths,
                                     got.humidity_tenths);
                errors += field_diff("temperature_tenths", 16'(want.temperature_tenths),
                                     16'(got.temperature_tenths));
                errors += field_diff("temperature_negative",
                                     16'(want.temperature_negative),
                                     16'(got.temperature_negative));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        cmd = 1'b0;
        line_level = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_START_LOW;
        cfg_data = '0;
        timing.start_low_ticks = START_LOW_RST;
        timing.start_high_ticks = START_HIGH_RST;
        timing.sample_delay_ticks = SAMPLE_DELAY_RST;
        timing.response_gap_ticks = RESPONSE_GAP_RST;
        seq_phase = PH_IDLE;
        seq_ticks = '0;
        seq_bits = '0;
        seq_frame = '0;
        seq_answered = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_ticks();
        test_default_timing();
        test_frame_extremes();
        test_no_response();
        test_start_while_busy();
        test_zero_delays();
        test_random_traffic();
        test_slow_extremes();

        while (expected_readouts.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
